@@ src/crsg_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crsg_pkg: shared types and constants of the constant-rate step generator
// Command codes, register indexes, payload words and the fixed-point
// constants of the millimetre to step conversion.
// ----------------------------------------------------------------------------
package crsg_pkg;

  // Command codes of an input word
  typedef enum logic [2:0] {
    CMD_TICK         = 3'd0,
    CMD_MOVE_ABS     = 3'd1,
    CMD_MOVE_STEPS   = 3'd2,
    CMD_SET_POSITION = 3'd3,
    CMD_ENABLE       = 3'd4,
    CMD_DISABLE      = 3'd5
  } cmd_t;

  // Register index, taken from paddr[2]
  localparam logic REG_STEP_INTERVAL   = 1'b0;
  localparam logic REG_STEPS_PER_METER = 1'b1;

  localparam int unsigned PADDR_W = 3;
  localparam int unsigned SPM_W   = 20;
  localparam int unsigned MM_W    = 24;

  localparam logic [31:0]      MAX32            = 32'hFFFF_FFFF;
  localparam logic [31:0]      INTERVAL_RESET   = 32'd1000;
  localparam logic [SPM_W-1:0] SPM_RESET        = 20'd80000;

  // steps = mag * spm / 256000, with 256000 = 2^11 * 125.
  // The 2^11 part is a shift, the 125 part a reciprocal multiply.
  localparam int unsigned PROD_W      = MM_W + SPM_W;
  localparam int unsigned DIV_SHIFT   = 11;
  localparam int unsigned X_W         = 32;
  localparam int unsigned RECIP_SHIFT = 38;
  localparam logic [X_W-1:0] RECIP    = 32'd2199023255;  // floor(2^38 / 125)
  localparam logic [X_W-1:0] DIVISOR  = 32'd125;
  localparam int unsigned Q_W         = 26;              // quotient < 2^26

  // Input word
  typedef struct packed {
    logic [2:0]        command;
    logic signed [23:0] target_mm_q8;
    logic [31:0]       step_count;
    logic              step_dir;
  } cmd_word_t;

  // Result word
  typedef struct packed {
    logic              step_pulse;
    logic              dir_level;
    logic              enable_n;
    logic signed [31:0] position_steps;
    logic [31:0]       remaining_steps;
  } res_word_t;

  // Command fields carried along the conversion pipeline
  typedef struct packed {
    cmd_t        cmd;
    logic        neg;
    logic [31:0] step_count;
    logic        step_dir;
  } ctl_t;

endpackage

@@ src/constant_rate_step_generator_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// constant_rate_step_generator_unit: constant-speed step pulse generator
// Ticks pace step pulses at a programmable interval; move commands load a
// distance and direction, with millimetre targets converted to steps.
// ----------------------------------------------------------------------------
// Usage:
//   The cmd channel (cmd_valid/cmd_ready/cmd_word) takes one command word per
//   cycle while cmd_ready is high; every word yields exactly one result word
//   on the res channel (res_valid/res_ready/res_word), in order.
//   An accepted word passes through the five-stage pipeline
//   (input register, spm multiply, reciprocal multiply, quotient fix-up,
//   sign apply) into the state/result register; a new word can enter each
//   stage as the word ahead of it moves on.
//   The state (position, steps left, direction, elapsed count, enable) is
//   updated as a word enters the result register.
//   Stalls: when res_ready is low, the pipeline still fills its empty
//   stages, so cmd_ready stays high until every stage holds a word.
//   Reset: rst (synchronous) empties the pipeline, loads the register reset
//   values, zeroes position and counters and disables the driver.
//   Config: APB writes at 0x0 (step interval) and 0x4 (steps per meter);
//   write only while the pipeline is empty.
// ----------------------------------------------------------------------------
module constant_rate_step_generator_unit
  import crsg_pkg::*;
#(
  parameter int unsigned POS_WIDTH = 32
) (
  input  logic               clk,
  input  logic               rst,
  // APB config port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  // command words
  input  logic               cmd_valid,
  output logic               cmd_ready,
  input  cmd_word_t          cmd_word,
  // result words
  output logic               res_valid,
  input  logic               res_ready,
  output res_word_t          res_word
);

  localparam int unsigned DW = (POS_WIDTH + 1 > 32) ? POS_WIDTH + 1 : 32;

  // config registers
  logic [31:0]      step_interval_us;
  logic [SPM_W-1:0] steps_per_meter;

  // pipeline valids and payloads
  logic s1_valid, s2_valid, s3_valid, s4_valid, s5_valid;
  ctl_t s1_ctl, s2_ctl, s3_ctl, s4_ctl, s5_ctl;
  logic [MM_W-1:0]      s1_mag;
  logic [PROD_W-1:0]    s2_prod;
  logic [X_W-1:0]       s3_x;
  logic [2*X_W-1:0]     s3_prod;
  logic [Q_W-1:0]       s4_q;
  logic [POS_WIDTH-1:0] s5_tgt;

  // state
  logic [POS_WIDTH-1:0] position, position_next;
  logic [31:0]          steps_left, steps_left_next;
  logic                 moving_positive, moving_positive_next;
  logic [31:0]          elapsed_us, elapsed_us_next;
  logic                 disabled, disabled_next;
  logic                 pulse;

  // stage load enables, chained back from the result register
  logic ld_out, ld5, ld4, ld3, ld2, ld1;

  assign ld_out    = !res_valid || res_ready;
  assign ld5       = !s5_valid || ld_out;
  assign ld4       = !s4_valid || ld5;
  assign ld3       = !s3_valid || ld4;
  assign ld2       = !s2_valid || ld3;
  assign ld1       = !s1_valid || ld2;
  assign cmd_ready = ld1;

  // APB register file
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      step_interval_us <= INTERVAL_RESET;
      steps_per_meter  <= SPM_RESET;
    end else if (psel && penable && pwrite) begin
      case (paddr[2])
        REG_STEP_INTERVAL:   step_interval_us <= pwdata;
        REG_STEPS_PER_METER: steps_per_meter  <= pwdata[SPM_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_STEP_INTERVAL:   prdata = step_interval_us;
      REG_STEPS_PER_METER: prdata = 32'(steps_per_meter);
      default:             prdata = '0;
    endcase
  end

  // pipeline valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      s3_valid  <= 1'b0;
      s4_valid  <= 1'b0;
      s5_valid  <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      if (ld1)    s1_valid  <= cmd_valid;
      if (ld2)    s2_valid  <= s1_valid;
      if (ld3)    s3_valid  <= s2_valid;
      if (ld4)    s4_valid  <= s3_valid;
      if (ld5)    s5_valid  <= s4_valid;
      if (ld_out) res_valid <= s5_valid;
    end
  end

  // stage 1: capture word, take magnitude of the millimetre target
  always_ff @(posedge clk) begin
    if (ld1) begin
      s1_ctl.cmd        <= cmd_t'(cmd_word.command);
      s1_ctl.neg        <= cmd_word.target_mm_q8[MM_W-1];
      s1_ctl.step_count <= cmd_word.step_count;
      s1_ctl.step_dir   <= cmd_word.step_dir;
      s1_mag            <= cmd_word.target_mm_q8[MM_W-1] ?
                           MM_W'(-cmd_word.target_mm_q8) : cmd_word.target_mm_q8;
    end
  end

  // stage 2: magnitude times steps per meter
  always_ff @(posedge clk) begin
    if (ld2) begin
      s2_ctl  <= s1_ctl;
      s2_prod <= PROD_W'(s1_mag) * PROD_W'(steps_per_meter);
    end
  end

  // stage 3: drop 2^11, multiply by reciprocal of 125
  always_ff @(posedge clk) begin
    if (ld3) begin
      s3_ctl  <= s2_ctl;
      s3_x    <= s2_prod[DIV_SHIFT +: X_W];
      s3_prod <= (2*X_W)'(s2_prod[DIV_SHIFT +: X_W]) * (2*X_W)'(RECIP);
    end
  end

  // stage 4: quotient estimate is exact or one low; fix with remainder
  logic [Q_W-1:0] q_est;
  logic [X_W-1:0] q_rem;

  always_comb begin
    q_est = s3_prod[RECIP_SHIFT +: Q_W];
    q_rem = s3_x - X_W'(X_W'(q_est) * DIVISOR);
  end

  always_ff @(posedge clk) begin
    if (ld4) begin
      s4_ctl <= s3_ctl;
      s4_q   <= (q_rem >= DIVISOR) ? q_est + Q_W'(1) : q_est;
    end
  end

  // stage 5: apply sign, wrap to position width
  logic [POS_WIDTH-1:0] q_pos;
  assign q_pos = POS_WIDTH'(s4_q);

  always_ff @(posedge clk) begin
    if (ld5) begin
      s5_ctl <= s4_ctl;
      s5_tgt <= s4_ctl.neg ? -q_pos : q_pos;
    end
  end

  // state update for the word entering the result register
  logic [31:0]          elapsed_inc;
  logic [POS_WIDTH:0]   diff;
  logic [POS_WIDTH:0]   diff_mag;
  logic [DW-1:0]        move_dist;

  always_comb begin
    position_next        = position;
    steps_left_next      = steps_left;
    moving_positive_next = moving_positive;
    elapsed_us_next      = elapsed_us;
    disabled_next        = disabled;
    pulse                = 1'b0;

    elapsed_inc = (elapsed_us == MAX32) ? elapsed_us : elapsed_us + 32'd1;
    diff        = {s5_tgt[POS_WIDTH-1], s5_tgt} - {position[POS_WIDTH-1], position};
    diff_mag    = diff[POS_WIDTH] ? -diff : diff;
    move_dist   = DW'(diff_mag);

    case (s5_ctl.cmd)
      CMD_TICK: begin
        elapsed_us_next = elapsed_inc;
        if (steps_left != 32'd0 && elapsed_inc >= step_interval_us) begin
          pulse           = 1'b1;
          position_next   = moving_positive ? position + POS_WIDTH'(1)
                                            : position - POS_WIDTH'(1);
          steps_left_next = steps_left - 32'd1;
          elapsed_us_next = '0;
        end
      end
      CMD_MOVE_ABS: begin
        steps_left_next = (move_dist > DW'(MAX32)) ? MAX32 : 32'(move_dist);
        // equal target keeps the current direction
        if (diff != '0) begin
          moving_positive_next = !diff[POS_WIDTH];
        end
      end
      CMD_MOVE_STEPS: begin
        position_next        = '0;
        moving_positive_next = s5_ctl.step_dir;
        steps_left_next      = s5_ctl.step_count;
      end
      CMD_SET_POSITION: position_next = s5_tgt;
      CMD_ENABLE:       disabled_next = 1'b0;
      CMD_DISABLE:      disabled_next = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      position        <= '0;
      steps_left      <= '0;
      moving_positive <= 1'b0;
      elapsed_us      <= '0;
      disabled        <= 1'b1;
    end else if (ld_out && s5_valid) begin
      position        <= position_next;
      steps_left      <= steps_left_next;
      moving_positive <= moving_positive_next;
      elapsed_us      <= elapsed_us_next;
      disabled        <= disabled_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (ld_out && s5_valid) begin
      res_word.step_pulse      <= pulse;
      res_word.dir_level       <= moving_positive_next;
      res_word.enable_n        <= disabled_next;
      res_word.position_steps  <= 32'(position_next);
      res_word.remaining_steps <= steps_left_next;
    end
  end

endmodule
